@@ src/orol_pkg.sv @@
// ----------------------------------------------------------------------------
// orol_pkg
// Types, widths and codes shared by the overwrite ring offset lookup block.
// ----------------------------------------------------------------------------
package orol_pkg;

	localparam int ENTRIES_DEFAULT = 16;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 16;
	localparam int OFFS_W = 20;
	localparam int SLOT_OUT_W = 4;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] record_address;
		logic [LEN_W-1:0]  record_length;
		logic [OFFS_W-1:0] char_pos;
	} in_item_t;

	typedef struct packed {
		logic                  found;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [ADDR_W-1:0]     found_address;
		logic [LEN_W-1:0]      found_length;
		logic [LEN_W-1:0]      byte_within_record;
		logic                  overwrote_oldest;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_PUT
	} state_t;

	typedef struct packed {
		logic add;
		logic find;
		logic step;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic hit;
		logic last;
	} ctrl_stat_t;

endpackage

@@ src/orol_ctrl.sv @@
// ----------------------------------------------------------------------------
// orol_ctrl
// Controller: sequences add and find items and owns the result valid flag.
// ----------------------------------------------------------------------------
module orol_ctrl
	import orol_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       item_cmd,
	output logic       result_valid,
	input  logic       result_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_cmd == CMD_ADD) begin
						ctl.add = 1'b1;
						state_d = S_PUT;
					end else begin
						ctl.find = 1'b1;
						state_d  = stat.empty ? S_PUT : S_WALK;
					end
				end
			end
			S_WALK: begin
				ctl.step = 1'b1;
				if (stat.hit || stat.last) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (!out_valid_q || result_ready) begin
					ctl.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

@@ src/orol_dpath.sv @@
// ----------------------------------------------------------------------------
// orol_dpath
// Datapath: ring positions, record memory, length accumulator and result.
// ----------------------------------------------------------------------------
module orol_dpath
	import orol_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  ctrl_cmd_t  ctl,
	output ctrl_stat_t stat,
	output out_item_t  result
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ACC_BASE = LEN_W + CNT_W;
	localparam int ACC_W = ((ACC_BASE > OFFS_W) ? ACC_BASE : OFFS_W) + 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

	logic [ADDR_W-1:0] addr_mem [ENTRIES];
	logic [LEN_W-1:0]  len_mem [ENTRIES];

	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic              ring_full_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  valid_q;
	logic [ACC_W-1:0]  acc_q;
	logic [OFFS_W-1:0] offs_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [LEN_W-1:0]  rd_len_q;
	out_item_t         res_q;
	out_item_t         out_q;

	logic [SLOT_W-1:0] rd_slot;
	logic [SLOT_W-1:0] write_next;
	logic [SLOT_W-1:0] read_next;
	logic [SLOT_W-1:0] idx_next;
	logic [CNT_W-1:0]  count;
	logic [ACC_W-1:0]  sum;
	logic [ACC_W-1:0]  offs_ext;
	logic [ACC_W-1:0]  diff;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+SLOT_OUT_W-1:0] wide;
		wide = {{SLOT_OUT_W{1'b0}}, s};
		return wide[SLOT_OUT_W-1:0];
	endfunction

	assign write_next = next_slot(write_slot_q);
	assign read_next  = next_slot(read_slot_q);
	assign idx_next   = next_slot(idx_q);
	assign rd_slot    = ctl.step ? idx_next : read_slot_q;

	always_comb begin
		if (ring_full_q) begin
			count = CNT_FULL;
		end else if (write_slot_q >= read_slot_q) begin
			count = CNT_W'(write_slot_q - read_slot_q);
		end else begin
			count = CNT_FULL - CNT_W'(read_slot_q - write_slot_q);
		end
	end

	assign sum      = acc_q + ACC_W'(rd_len_q);
	assign offs_ext = ACC_W'(offs_q);
	assign diff     = offs_ext - acc_q;

	assign stat.empty = (count == '0);
	assign stat.hit   = (offs_ext < sum);
	assign stat.last  = ((pos_q + 1'b1) == valid_q);

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			addr_mem[write_slot_q] <= item.record_address;
			len_mem[write_slot_q]  <= item.record_length;
		end
		rd_addr_q <= addr_mem[rd_slot];
		rd_len_q  <= len_mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			ring_full_q  <= 1'b0;
		end else if (ctl.add) begin
			write_slot_q <= write_next;
			if (ring_full_q) begin
				read_slot_q <= read_next;
			end else if (write_next == read_slot_q) begin
				ring_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			res_q                  <= '0;
			res_q.slot_index       <= slot_out(write_slot_q);
			res_q.overwrote_oldest <= ring_full_q;
		end else if (ctl.find) begin
			res_q   <= '0;
			idx_q   <= read_slot_q;
			pos_q   <= '0;
			valid_q <= count;
			acc_q   <= '0;
			offs_q  <= item.char_pos;
		end else if (ctl.step) begin
			if (stat.hit) begin
				res_q.found              <= 1'b1;
				res_q.slot_index         <= slot_out(idx_q);
				res_q.found_address      <= rd_addr_q;
				res_q.found_length       <= rd_len_q;
				res_q.byte_within_record <= diff[LEN_W-1:0];
				res_q.overwrote_oldest   <= 1'b0;
			end else begin
				res_q <= '0;
			end
			idx_q <= idx_next;
			pos_q <= pos_q + 1'b1;
			acc_q <= sum;
		end
		if (ctl.load) begin
			out_q <= res_q;
		end
	end

	assign result = out_q;

endmodule

@@ src/overwrite_ring_offset_lookup.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_offset_lookup
// Ring of address and length records that overwrites the oldest record when
// full, with a lookup of the record that holds a character offset.
// ----------------------------------------------------------------------------
//  Channel   Signals                             Role
//  item      item_valid, item_ready, item        add or find request in
//  result    result_valid, result_ready, result  one result per item out
//
// An add goes from acceptance through the put state back to idle before the next
// acceptance. A find first walks N records, at most ENTRIES, and skips the walk
// when the ring is empty; the walk reads one record per cycle from the registered memory port.
// Reset empties the ring at once; the record memory itself is not cleared.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module overwrite_ring_offset_lookup
	import orol_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	ctrl_cmd_t  ctl;
	ctrl_stat_t stat;

	orol_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_cmd     (item.cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.ctl          (ctl)
	);

	orol_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.stat   (stat),
		.result (result)
	);

endmodule

@@ tb/overwrite_ring_offset_lookup_test.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_offset_lookup_test
// Self-checking bench for the overwrite ring offset lookup block. A shadow
// ring tracks every accepted add and predicts each find. Results are checked
// field by field, in order. The run covers directed corner items, then random
// add and find traffic under shifting idle patterns and back pressure.
// ----------------------------------------------------------------------------
module overwrite_ring_offset_lookup_test;
	import orol_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 250;

	class ring_shadow;
		logic [ADDR_W-1:0] addr_mem [ENTRIES_DEFAULT];
		logic [LEN_W-1:0]  len_mem [ENTRIES_DEFAULT];
		int                wr_pos = 0;
		int                rd_pos = 0;
		bit                full = 0;
		out_item_t         pending_results[$];
		int                errors = 0;

		function int stored_count();
			if (full)
				return ENTRIES_DEFAULT;
			return (wr_pos - rd_pos + ENTRIES_DEFAULT) % ENTRIES_DEFAULT;
		endfunction

		function int stored_bytes();
			int total;
			total = 0;
			for (int i = 0; i < stored_count(); i++)
				total += int'(len_mem[(rd_pos + i) % ENTRIES_DEFAULT]);
			return total;
		endfunction

		function void take_item(in_item_t it);
			out_item_t r;
			int        acc;
			int        idx;
			r = '0;
			if (it.cmd == CMD_ADD) begin
				addr_mem[wr_pos] = it.record_address;
				len_mem[wr_pos] = it.record_length;
				r.slot_index = SLOT_OUT_W'(wr_pos);
				if (full) begin
					r.overwrote_oldest = 1'b1;
					rd_pos = (rd_pos + 1) % ENTRIES_DEFAULT;
					wr_pos = (wr_pos + 1) % ENTRIES_DEFAULT;
				end else begin
					wr_pos = (wr_pos + 1) % ENTRIES_DEFAULT;
					if (wr_pos == rd_pos)
						full = 1'b1;
				end
			end else begin
				acc = 0;
				for (int i = 0; i < stored_count(); i++) begin
					idx = (rd_pos + i) % ENTRIES_DEFAULT;
					if (int'(it.char_pos) < acc + int'(len_mem[idx])) begin
						r.found = 1'b1;
						r.slot_index = SLOT_OUT_W'(idx);
						r.found_address = addr_mem[idx];
						r.found_length = len_mem[idx];
						r.byte_within_record = LEN_W'(int'(it.char_pos) - acc);
						break;
					end
					acc += int'(len_mem[idx]);
				end
			end
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("found", 32'(want.found), 32'(got.found));
			compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
			compare_field("found_address", want.found_address, got.found_address);
			compare_field("found_length", 32'(want.found_length), 32'(got.found_length));
			compare_field("byte_within_record", 32'(want.byte_within_record),
				32'(got.byte_within_record));
			compare_field("overwrote_oldest", 32'(want.overwrote_oldest),
				32'(got.overwrote_oldest));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	in_item_t   item;
	logic       result_valid;
	logic       result_ready;
	out_item_t  result;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_left;
	int         cycle_count = 0;
	ring_shadow shadow;

	overwrite_ring_offset_lookup u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			shadow.check_result(result);
	end

	initial begin
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ready = 1'b0;
				hold_left--;
			end else begin
				result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Starts and ends on a falling edge; valid stays high between back-to-back items.
	task automatic send_item(in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		shadow.take_item(it);
		@(negedge clk);
	endtask

	task automatic send_add(logic [ADDR_W-1:0] address, logic [LEN_W-1:0] length);
		in_item_t it;
		it.cmd = CMD_ADD;
		it.record_address = address;
		it.record_length = length;
		it.char_pos = OFFS_W'($urandom);
		send_item(it);
	endtask

	task automatic send_find(logic [OFFS_W-1:0] offset);
		in_item_t it;
		it.cmd = CMD_FIND;
		it.record_address = $urandom;
		it.record_length = LEN_W'($urandom);
		it.char_pos = offset;
		send_item(it);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Most finds land inside the stored data; some sit just past it or anywhere.
	function automatic in_item_t random_request();
		in_item_t it;
		int       total;
		int       pick;
		total = shadow.stored_bytes();
		it.cmd = ($urandom_range(0, 99) < 45) ? CMD_ADD : CMD_FIND;
		it.record_address = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			it.record_length = '0;
		else if (pick < 20)
			it.record_length = LEN_W'($urandom);
		else if (pick < 25)
			it.record_length = '1;
		else
			it.record_length = LEN_W'($urandom_range(1, 64));
		pick = $urandom_range(0, 99);
		if (pick < 75 && total > 0)
			it.char_pos = OFFS_W'($urandom_range(0, total - 1));
		else if (pick < 85)
			it.char_pos = OFFS_W'(total);
		else
			it.char_pos = OFFS_W'($urandom);
		return it;
	endfunction

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		shadow = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_find('0);
		send_add('0, '0);
		send_find('0);
		send_add('1, '1);
		send_find('0);
		send_find(20'h0FFFE);
		send_find(20'h0FFFF);
		send_add(32'hA5A5_5A5A, 16'd1);
		send_find(20'h0FFFF);
		send_find('1);
		repeat (13)
			send_add($urandom, LEN_W'($urandom_range(0, 300)));
		send_add(32'h1234_5678, 16'h8000);
		send_find(OFFS_W'(shadow.stored_bytes() - 1));

		send_idle_pct = 19;
		recv_idle_pct = 45;
		for (int i = 0; i < 135; i++) begin
			if (i == 40)
				hold_left = HOLD_CYCLES;
			send_item(random_request());
		end

		send_idle_pct = 45;
		recv_idle_pct = 19;
		for (int i = 0; i < 135; i++) begin
			if (i == 60)
				wait_drained();
			send_item(random_request());
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 130; i++)
			send_item(random_request());

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
src/orol_pkg.sv
src/orol_ctrl.sv
src/orol_dpath.sv
src/overwrite_ring_offset_lookup.sv
tb/overwrite_ring_offset_lookup_test.sv
